// ----- rtl/char_lcd_4bit_write_sequencer_assert.svh -----
// assertion macros for the rtl
`ifndef CHAR_LCD_4BIT_WRITE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_4BIT_WRITE_SEQUENCER_ASSERT_SVH

// clocked on clk_i, off while rst_ni is low
`define CLCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked on clk_i, checked during reset as well
`define CLCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/clcd_pkg.sv -----
`default_nettype none

package clcd_pkg;

  typedef enum logic [2:0] {
    FUNC_CHAR  = 3'd0,
    FUNC_CMD   = 3'd1,
    FUNC_INIT  = 3'd2,
    FUNC_CLEAR = 3'd3,
    FUNC_GOTO  = 3'd4
  } func_e;

  localparam int unsigned IDX_W = 4;
  localparam int unsigned WAIT_W = 14;

  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;

  localparam logic [IDX_W-1:0] INIT_CMD_IDX  = 4'd4;
  localparam logic [IDX_W-1:0] INIT_LAST_IDX = 4'd11;
  localparam logic [IDX_W-1:0] CLEAR_LAST_IDX = 4'd3;

  localparam logic [WAIT_W-1:0] W_STROBE     = 14'd6;
  localparam logic [WAIT_W-1:0] W_CHAR_END   = 14'd40;
  localparam logic [WAIT_W-1:0] W_CMD_END    = 14'd46;
  localparam logic [WAIT_W-1:0] W_POWER_UP   = 14'd15000;
  localparam logic [WAIT_W-1:0] W_INIT_FIRST = 14'd5006;
  localparam logic [WAIT_W-1:0] W_INIT_NIB   = 14'd166;
  localparam logic [WAIT_W-1:0] W_CLEAR_END  = 14'd1646;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;
  localparam logic [3:0] NIB_CLEAR = 4'h1;
  localparam logic [3:0] NIB_HOME  = 4'h2;

  localparam logic [7:0] DDRAM_SET = 8'h80;
  localparam logic [7:0] LINE2_OFS = 8'h3F;
  localparam logic [7:0] LINE3_OFS = 8'h13;
  localparam logic [7:0] LINE4_OFS = 8'h53;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic             prefix;
    logic [IDX_W-1:0] idx;
    logic [1:0]       phase;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic req_init;
    logic nib_last;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [7:0] init_cmd(input logic [1:0] sel);
    logic [7:0] c;
    unique case (sel)
      2'd0:    c = 8'h06;
      2'd1:    c = 8'h0C;
      2'd2:    c = 8'h14;
      default: c = 8'h28;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/clcd_datapath.sv -----
`default_nettype none

module clcd_datapath import clcd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [2:0]          func_i,
  input  wire logic [7:0]          value_i,
  input  wire logic [3:0]          line_i,
  input  wire logic [4:0]          column_i,
  input  wire ctl_cmd_t            cmd_i,
  output ctl_sts_t                 sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               port_value_o,
  output logic [WAIT_W-1:0]        wait_us_o,
  output logic                     last_o
);

  func_e             func_q;
  logic [7:0]        byte_q;
  logic              out_valid_q;
  logic [7:0]        port_q;
  logic [WAIT_W-1:0] wait_q;
  logic              last_q;

  logic              line_ok;
  logic              col_ok;
  logic              req_ok;
  logic              req_init;
  logic [7:0]        goto_addr;
  logic [7:0]        col8;
  logic [3:0]        nib;
  logic              rs;
  logic [WAIT_W-1:0] w_hold;
  logic              nib_last;
  logic [IDX_W-1:0]  init_ofs;
  logic [7:0]        init_byte;
  logic [7:0]        port_d;
  logic [WAIT_W-1:0] wait_d;
  logic              last_d;

  // request check and goto address
  assign col8    = {3'b000, column_i};
  assign line_ok = (line_i >= 4'd1) && (line_i <= 4'd4);
  assign col_ok  = (column_i >= 5'd1) && (column_i <= 5'd20);

  always_comb begin
    unique case (line_i)
      4'd1:    goto_addr = col8 - 8'd1;
      4'd2:    goto_addr = LINE2_OFS + col8;
      4'd3:    goto_addr = LINE3_OFS + col8;
      default: goto_addr = LINE4_OFS + col8;
    endcase
  end

  always_comb begin
    req_init = 1'b0;
    unique case (func_i) inside
      FUNC_CHAR, FUNC_CMD, FUNC_CLEAR: req_ok = 1'b1;
      FUNC_INIT: begin
        req_ok   = 1'b1;
        req_init = 1'b1;
      end
      FUNC_GOTO: req_ok = line_ok && col_ok;
      default:   req_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      byte_q <= (func_i == FUNC_GOTO) ? (goto_addr + DDRAM_SET) : value_i;
    end
  end

  // nibble selection per request type
  assign init_ofs  = cmd_i.idx - INIT_CMD_IDX;
  assign init_byte = init_cmd(init_ofs[2:1]);

  always_comb begin
    nib      = 4'h0;
    rs       = 1'b0;
    w_hold   = W_STROBE;
    nib_last = 1'b0;
    unique case (func_q) inside
      FUNC_CHAR: begin
        rs       = 1'b1;
        nib      = cmd_i.idx[0] ? byte_q[3:0] : byte_q[7:4];
        w_hold   = cmd_i.idx[0] ? W_CHAR_END : W_STROBE;
        nib_last = cmd_i.idx[0];
      end
      FUNC_CMD, FUNC_GOTO: begin
        nib      = cmd_i.idx[0] ? byte_q[3:0] : byte_q[7:4];
        w_hold   = cmd_i.idx[0] ? W_CMD_END : W_STROBE;
        nib_last = cmd_i.idx[0];
      end
      FUNC_INIT: begin
        if (cmd_i.idx < INIT_CMD_IDX) begin
          nib    = (cmd_i.idx[1:0] == 2'd3) ? NIB_4BIT : NIB_WAKE;
          w_hold = (cmd_i.idx[1:0] == 2'd0) ? W_INIT_FIRST : W_INIT_NIB;
        end else begin
          nib    = cmd_i.idx[0] ? init_byte[3:0] : init_byte[7:4];
          w_hold = cmd_i.idx[0] ? W_CMD_END : W_STROBE;
        end
        nib_last = (cmd_i.idx == INIT_LAST_IDX);
      end
      FUNC_CLEAR: begin
        nib      = cmd_i.idx[0] ? (cmd_i.idx[1] ? NIB_HOME : NIB_CLEAR) : 4'h0;
        w_hold   = cmd_i.idx[0] ? W_CLEAR_END : W_STROBE;
        nib_last = (cmd_i.idx == CLEAR_LAST_IDX);
      end
      default: nib_last = 1'b1;
    endcase
  end

  always_comb begin
    if (cmd_i.prefix) begin
      port_d = 8'h00;
      wait_d = W_POWER_UP;
      last_d = 1'b0;
    end else begin
      port_d = {1'b0, (cmd_i.phase == PH_HIGH), rs, 1'b0, nib};
      unique case (cmd_i.phase)
        PH_SETUP: wait_d = '0;
        PH_HIGH:  wait_d = W_STROBE;
        default:  wait_d = w_hold;
      endcase
      last_d = nib_last && (cmd_i.phase == PH_HOLD);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      port_q <= port_d;
      wait_q <= wait_d;
      last_q <= last_d;
    end
  end

  assign sts_o.req_ok   = req_ok;
  assign sts_o.req_init = req_init;
  assign sts_o.nib_last = nib_last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign port_value_o   = port_q;
  assign wait_us_o      = wait_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ----- rtl/clcd_ctrl.sv -----
`default_nettype none

`include "char_lcd_4bit_write_sequencer_assert.svh"

module clcd_ctrl import clcd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output ctl_cmd_t      cmd_o,
  input  wire ctl_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PREFIX = 3'b010,
    ST_RUN    = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       phase_q, phase_d;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    phase_d      = phase_q;
    cmd_o.load   = 1'b0;
    cmd_o.emit   = 1'b0;
    cmd_o.prefix = (state_q == ST_PREFIX);
    cmd_o.idx    = idx_q;
    cmd_o.phase  = phase_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.req_ok) begin
            state_d = sts_i.req_init ? ST_PREFIX : ST_RUN;
            idx_d   = '0;
            phase_d = PH_SETUP;
          end
        end
      end
      ST_PREFIX: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (phase_q == PH_HOLD) begin
            phase_d = PH_SETUP;
            if (sts_i.nib_last) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      phase_q <= PH_SETUP;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `CLCD_ASSERT(a_phase_range, phase_q != 2'd3, "nibble phase out of range")
  `CLCD_ASSERT(a_idx_range, idx_q <= INIT_LAST_IDX, "nibble index past end of longest run")
  `CLCD_ASSERT(a_run_ends,
      (state_q == ST_RUN && phase_q == PH_HOLD && sts_i.nib_last && sts_i.out_free)
      |=> state_q == ST_IDLE, "run did not end after last write")
  `CLCD_ASSERT(a_prefix_to_run,
      (state_q == ST_PREFIX && sts_i.out_free)
      |=> (state_q == ST_RUN && idx_q == '0 && phase_q == PH_SETUP),
      "power-up prefix not followed by first nibble")

endmodule

`default_nettype wire

// ----- rtl/char_lcd_4bit_write_sequencer.sv -----
`default_nettype none

// Character LCD write sequencer for a 4-bit parallel character panel driven through an 8-bit
// port byte (bit 6 E, bit 5 RS, bits 3-0 data nibble). Each accepted request expands
// into a run of port writes, each with the microseconds to wait before the next write,
// and last marks the final write of the run: 6 writes for a character, a command or a
// goto, 12 for clear and home, 37 for the power-up sequence, none for an out-of-range
// goto or an unused func code. The controller steps through the run one write per
// cycle into a single output register while the output side does not stall;
// the next request is taken once the final write of the current run has been
// loaded into that register.

module char_lcd_4bit_write_sequencer import clcd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        func_i,
  input  wire logic [7:0]        value_i,
  input  wire logic [3:0]        line_i,
  input  wire logic [4:0]        column_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             port_value_o,
  output logic [WAIT_W-1:0]      wait_us_o,
  output logic                   last_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  clcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  clcd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .func_i       (func_i),
    .value_i      (value_i),
    .line_i       (line_i),
    .column_i     (column_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .port_value_o (port_value_o),
    .wait_us_o    (wait_us_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- sim/tb_char_lcd_4bit_write_sequencer.sv -----
`timescale 1ns / 1ps

module tb_char_lcd_4bit_write_sequencer;
  import clcd_pkg::*;

  localparam logic [7:0] E_BIT = 8'h40;
  localparam logic [7:0] RS_BIT = 8'h20;
  localparam logic [7:0] DDRAM_CMD = 8'h80;
  localparam logic [7:0] ROW2_OFS = 8'h3F;
  localparam logic [7:0] ROW3_OFS = 8'h13;
  localparam logic [7:0] ROW4_OFS = 8'h53;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_CURSOR_SHIFT = 8'h14;
  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME = 8'h02;
  localparam logic [3:0] NIB_WAKEUP = 4'h3;
  localparam logic [3:0] NIB_GO_4BIT = 4'h2;
  localparam logic [3:0] LINE_FIRST = 4'd1;
  localparam logic [3:0] LINE_LAST = 4'd4;
  localparam logic [4:0] COL_FIRST = 5'd1;
  localparam logic [4:0] COL_LAST = 5'd20;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0]        port;
    logic [WAIT_W-1:0] wait_us;
    logic              last;
  } lcd_write_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] value;
    logic [3:0] line;
    logic [4:0] column;
    logic       sync;
  } lcd_req_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] func_i = '0;
  logic [7:0] value_i = '0;
  logic [3:0] line_i = '0;
  logic [4:0] column_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] port_value_o;
  logic [WAIT_W-1:0] wait_us_o;
  logic last_o;

  lcd_req_t req_q[$];
  lcd_write_t run_q[$];
  lcd_write_t lcd_write_q[$];
  logic in_xfer = 1'b0;
  int err_cnt = 0;
  int writes_seen = 0;
  int idle_cnt = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  int mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  char_lcd_4bit_write_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .line_i      (line_i),
    .column_i    (column_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .port_value_o(port_value_o),
    .wait_us_o   (wait_us_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void emit_write(logic [7:0] port, logic [WAIT_W-1:0] us);
    lcd_write_t w;
    w.port = port;
    w.wait_us = us;
    w.last = 1'b0;
    run_q.push_back(w);
  endfunction

  function automatic void stretch_wait(int unsigned extra);
    int n;
    n = run_q.size();
    if (n != 0) begin
      run_q[n-1].wait_us = run_q[n-1].wait_us + WAIT_W'(extra);
    end
  endfunction

  function automatic void emit_nibble(logic [3:0] nib, logic [7:0] rs);
    logic [7:0] base;
    base = rs | {4'h0, nib};
    emit_write(base, 14'd0);
    emit_write(base | E_BIT, 14'd6);
    emit_write(base, 14'd6);
  endfunction

  function automatic void emit_cmd(logic [7:0] cmd);
    emit_nibble(cmd[7:4], 8'h00);
    emit_nibble(cmd[3:0], 8'h00);
    stretch_wait(40);
  endfunction

  function automatic void emit_char(logic [7:0] ch);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = RS_BIT | {4'h0, ch[7:4]};
    lo = RS_BIT | {4'h0, ch[3:0]};
    emit_write(hi, 14'd0);
    emit_write(hi | E_BIT, 14'd6);
    emit_write(hi, 14'd6);
    emit_write(lo, 14'd0);
    emit_write(lo | E_BIT, 14'd6);
    emit_write(lo, 14'd40);
  endfunction

  function automatic void predict_lcd_run(logic [2:0] func, logic [7:0] value,
                                          logic [3:0] line, logic [4:0] column);
    logic [7:0] addr;
    run_q.delete();
    case (func)
      FUNC_CHAR: emit_char(value);
      FUNC_CMD: emit_cmd(value);
      FUNC_INIT: begin
        emit_write(8'h00, 14'd15000);
        emit_nibble(NIB_WAKEUP, 8'h00);
        stretch_wait(5000);
        emit_nibble(NIB_WAKEUP, 8'h00);
        stretch_wait(160);
        emit_nibble(NIB_WAKEUP, 8'h00);
        stretch_wait(160);
        emit_nibble(NIB_GO_4BIT, 8'h00);
        stretch_wait(160);
        emit_cmd(CMD_ENTRY_MODE);
        emit_cmd(CMD_DISPLAY_ON);
        emit_cmd(CMD_CURSOR_SHIFT);
        emit_cmd(CMD_FUNC_SET);
      end
      FUNC_CLEAR: begin
        emit_cmd(CMD_CLEAR);
        stretch_wait(1600);
        emit_cmd(CMD_HOME);
        stretch_wait(1600);
      end
      FUNC_GOTO: begin
        if (line >= LINE_FIRST && line <= LINE_LAST && column >= COL_FIRST &&
            column <= COL_LAST) begin
          if (line == 4'd1) addr = {3'b000, column} - 8'd1;
          else if (line == 4'd2) addr = ROW2_OFS + {3'b000, column};
          else if (line == 4'd3) addr = ROW3_OFS + {3'b000, column};
          else addr = ROW4_OFS + {3'b000, column};
          emit_cmd(DDRAM_CMD + addr);
        end
      end
      default: ;
    endcase
    if (run_q.size() != 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[i]) lcd_write_q.push_back(run_q[i]);
  endfunction

  task automatic add_req(logic [2:0] f, logic [7:0] v, logic [3:0] l, logic [4:0] c,
                         logic sync);
    lcd_req_t r;
    r.func = f;
    r.value = v;
    r.line = l;
    r.column = c;
    r.sync = sync;
    req_q.push_back(r);
  endtask

  // sender
  always @(negedge clk_i) begin : drive
    lcd_req_t req;
    if (rst_ni && (!in_valid_i || in_xfer)) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() == 0 || (req_q[0].sync && lcd_write_q.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        req = req_q.pop_front();
        func_i <= req.func;
        value_i <= req.value;
        line_i <= req.line;
        column_i <= req.column;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern with long hold-offs
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && writes_seen >= 60) ||
                 (holds_done == 1 && writes_seen >= 400)) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin : watch
    lcd_write_t exp_w;
    in_xfer <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_lcd_run(func_i, value_i, line_i, column_i);
      if (out_valid_o && !out_stall_i) begin
        writes_seen <= writes_seen + 1;
        if (lcd_write_q.size() == 0) begin
          $error("unexpected transfer: port_value %0h wait_us %0d last %0b",
                 port_value_o, wait_us_o, last_o);
          err_cnt = err_cnt + 1;
        end else begin
          exp_w = lcd_write_q.pop_front();
          if (port_value_o !== exp_w.port) begin
            $error("port_value: expected %0h, got %0h", exp_w.port, port_value_o);
            err_cnt = err_cnt + 1;
          end
          if (wait_us_o !== exp_w.wait_us) begin
            $error("wait_us: expected %0d, got %0d", exp_w.wait_us, wait_us_o);
            err_cnt = err_cnt + 1;
          end
          if (last_o !== exp_w.last) begin
            $error("last: expected %0b, got %0b", exp_w.last, last_o);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin
    logic [2:0] f;
    logic [3:0] l;
    logic [4:0] c;
    int pick;

    // directed
    add_req(FUNC_CHAR, 8'h00, 4'($urandom), 5'($urandom), 1'b0);
    add_req(FUNC_CHAR, 8'hFF, 4'($urandom), 5'($urandom), 1'b0);
    add_req(FUNC_CMD, 8'h00, 4'($urandom), 5'($urandom), 1'b0);
    add_req(FUNC_CMD, 8'hFF, 4'($urandom), 5'($urandom), 1'b0);
    add_req(FUNC_INIT, 8'($urandom), 4'($urandom), 5'($urandom), 1'b1);
    add_req(FUNC_CLEAR, 8'($urandom), 4'($urandom), 5'($urandom), 1'b0);
    for (int r = LINE_FIRST; r <= LINE_LAST; r++) begin
      add_req(FUNC_GOTO, 8'($urandom), 4'(r), COL_FIRST, 1'b0);
      add_req(FUNC_GOTO, 8'($urandom), 4'(r), COL_LAST, 1'b0);
    end
    add_req(FUNC_GOTO, 8'($urandom), 4'd0, 5'd5, 1'b0);
    add_req(FUNC_GOTO, 8'($urandom), 4'd5, 5'd5, 1'b0);
    add_req(FUNC_GOTO, 8'($urandom), 4'd15, 5'd5, 1'b0);
    add_req(FUNC_GOTO, 8'($urandom), 4'd2, 5'd0, 1'b0);
    add_req(FUNC_GOTO, 8'($urandom), 4'd3, 5'd21, 1'b0);
    add_req(FUNC_GOTO, 8'($urandom), 4'd1, 5'd31, 1'b0);
    for (int u = int'(FUNC_GOTO) + 1; u < 8; u++) begin
      add_req(3'(u), 8'($urandom), 4'($urandom), 5'($urandom), 1'b0);
    end
    add_req(FUNC_CHAR, 8'h5A, 4'($urandom), 5'($urandom), 1'b0);

    // random
    for (int i = 0; i < 100; i++) begin
      pick = $urandom_range(0, 99);
      l = 4'($urandom);
      c = 5'($urandom);
      if (pick < 30) f = FUNC_CHAR;
      else if (pick < 55) f = FUNC_CMD;
      else if (pick < 60) f = FUNC_INIT;
      else if (pick < 70) f = FUNC_CLEAR;
      else if (pick < 95) begin
        f = FUNC_GOTO;
        if ($urandom_range(0, 4) != 0) begin
          l = 4'($urandom_range(LINE_FIRST, LINE_LAST));
          c = 5'($urandom_range(COL_FIRST, COL_LAST));
        end
      end else f = 3'($urandom_range(int'(FUNC_GOTO) + 1, 7));
      add_req(f, 8'($urandom), l, c, $urandom_range(0, 19) == 0);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (lcd_write_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
